>>> rtl/issr_pkg.sv
// ----------------------------------------------------------------------------
// issr_pkg
// Types and constants shared by the servo and sonar register map.
// ----------------------------------------------------------------------------
package issr_pkg;

	typedef enum logic [1:0] {
		OP_ADDR = 2'd0,
		OP_RX   = 2'd1,
		OP_TX   = 2'd2,
		OP_ECHO = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  rx_byte;
		logic [15:0] echo_rise;
		logic [15:0] echo_fall;
	} req_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        tx_valid;
		logic        servo_update;
		logic [13:0] servo_compare;
		logic        irq_pulse;
		logic [7:0]  distance_cm;
	} rsp_t;

	// set commands
	localparam logic [7:0] CMD_SET_CONFIG = 8'h9E;
	localparam logic [7:0] CMD_SET_MODE   = 8'hA1;
	localparam logic [7:0] CMD_SET_IRQ    = 8'hA2;
	localparam logic [7:0] CMD_SET_SERVO  = 8'hA3;

	// get commands
	localparam logic [7:0] CMD_GET_CONFIG = 8'h1E;
	localparam logic [7:0] CMD_GET_TYPE   = 8'h1F;
	localparam logic [7:0] CMD_GET_EVENT  = 8'h20;
	localparam logic [7:0] CMD_GET_DIST   = 8'h21;
	localparam logic [7:0] CMD_GET_SERVO  = 8'h23;

	localparam logic [7:0] DEVICE_TYPE = 8'h41;
	localparam logic [7:0] TX_SECOND   = 8'hFE;
	localparam logic [7:0] TX_FILL     = 8'hFF;

	localparam logic [2:0] INDEX_MAX = 3'd7;
	localparam int         INDEX_SPAN = 8;

	localparam logic [5:0] THRESHOLD_RESET = 6'd10;

	// echo width to centimeters: divide by 58 via reciprocal multiply
	localparam int          ECHO_DIV    = 58;
	localparam logic [7:0]  DIST_LIMIT  = 8'd150;
	localparam int          ECHO_SHIFT  = 19;
	localparam logic [13:0] ECHO_RECIP  = 14'(((1 << ECHO_SHIFT) + ECHO_DIV - 1) / ECHO_DIV);
	localparam logic [15:0] ECHO_CLAMP  = 16'((151) * ECHO_DIV);
	// lowest negative width whose quotient still truncates to zero
	localparam logic [15:0] ECHO_NEG_LO = 16'(65536 - ECHO_DIV + 1);

	localparam logic [13:0] SERVO_SCALE  = 14'd40;
	localparam logic [13:0] SERVO_OFFSET = 14'd360;

endpackage

>>> rtl/i2c_servo_sonar_register_map.sv
// path: a request is captured in the input register, and its response is
//   loaded from there into the output register once the output side is free
// throughput: one request per cycle, limited only by stall on the response side
// reset: arst_n clears valid flags and map state, not req_s1/rsp; threshold to ten, rest to zero
// ----------------------------------------------------------------------------
// i2c_servo_sonar_register_map
// Register map of an i2c slave board with a servo and an ultrasonic ranger:
// command buffer, set/get decode, echo distance and threshold event.
// ----------------------------------------------------------------------------
module i2c_servo_sonar_register_map #(
	parameter int BUFFER_DEPTH = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  issr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output issr_pkg::rsp_t rsp
);
	import issr_pkg::*;

	// byte index stops at seven, so entries past that are never written
	localparam int STORE_DEPTH = (BUFFER_DEPTH < INDEX_SPAN) ? BUFFER_DEPTH : INDEX_SPAN;

	logic        valid_s1;
	req_t        req_s1;
	logic        out_free;
	logic        fire_s1;

	logic [7:0]  buf_q [STORE_DEPTH];
	logic [2:0]  idx_q;
	logic [7:0]  config_q;
	logic [7:0]  angle_q;
	logic [7:0]  mode_q;
	logic        irq_en_q;
	logic [5:0]  thresh_q;
	logic [7:0]  dist_q;
	logic [7:0]  event_q;

	logic [STORE_DEPTH-1:0] wr_en;
	logic [7:0]  b0_next;
	logic [7:0]  b1_next;
	logic [2:0]  idx_inc;
	logic [2:0]  idx_next;
	logic [7:0]  config_next;
	logic [7:0]  angle_next;
	logic [7:0]  mode_next;
	logic        irq_en_next;
	logic [5:0]  thresh_next;
	logic [7:0]  dist_next;
	logic [7:0]  event_next;

	logic [15:0] diff;
	logic [27:0] prod;
	logic [7:0]  cm;
	rsp_t        rsp_d;

	assign out_free  = !rsp_valid || !rsp_stall;
	assign fire_s1   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	// buffer write enables, one per stored entry
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_wr
		assign wr_en[i] = (req_s1.op == OP_RX) && (idx_q == 3'(i));
	end

	assign b0_next = wr_en[0] ? req_s1.rx_byte : buf_q[0];
	assign b1_next = wr_en[1] ? req_s1.rx_byte : buf_q[1];
	assign idx_inc = (idx_q == INDEX_MAX) ? INDEX_MAX : idx_q + 3'd1;

	// echo distance
	assign diff = req_s1.echo_fall - req_s1.echo_rise;
	assign prod = 28'(diff[13:0]) * 28'(ECHO_RECIP);

	always_comb begin
		if (diff[15]) begin
			// small negative widths truncate to zero
			cm = (diff >= ECHO_NEG_LO) ? 8'd0 : DIST_LIMIT;
		end else if (diff >= ECHO_CLAMP) begin
			cm = DIST_LIMIT;
		end else begin
			cm = prod[ECHO_SHIFT +: 8];
		end
	end

	always_comb begin
		idx_next    = idx_q;
		config_next = config_q;
		angle_next  = angle_q;
		mode_next   = mode_q;
		irq_en_next = irq_en_q;
		thresh_next = thresh_q;
		dist_next   = dist_q;
		event_next  = event_q;
		rsp_d       = '0;

		case (req_s1.op)
			OP_ADDR: begin
				idx_next = 3'd0;
			end
			OP_RX: begin
				idx_next = idx_inc;
				// command in byte 0 is reapplied with whatever byte 1 holds
				case (b0_next)
					CMD_SET_CONFIG: config_next = b1_next;
					CMD_SET_SERVO: begin
						angle_next         = b1_next;
						rsp_d.servo_update = 1'b1;
					end
					CMD_SET_MODE:   mode_next = b1_next;
					CMD_SET_IRQ: begin
						irq_en_next = b1_next[0];
						thresh_next = b1_next[7:2];
					end
					default: ;
				endcase
			end
			OP_TX: begin
				idx_next       = idx_inc;
				rsp_d.tx_valid = 1'b1;
				if (idx_q == 3'd0) begin
					case (buf_q[0])
						CMD_GET_CONFIG: rsp_d.tx_byte = config_q;
						CMD_GET_TYPE:   rsp_d.tx_byte = DEVICE_TYPE;
						CMD_GET_EVENT: begin
							rsp_d.tx_byte = event_q;
							event_next    = 8'd0;
						end
						CMD_GET_DIST:   rsp_d.tx_byte = dist_q;
						CMD_GET_SERVO:  rsp_d.tx_byte = angle_q;
						default:        rsp_d.tx_byte = TX_FILL;
					endcase
				end else if (idx_q == 3'd1) begin
					rsp_d.tx_byte = TX_SECOND;
				end else begin
					rsp_d.tx_byte = TX_FILL;
				end
			end
			OP_ECHO: begin
				if (irq_en_q && (cm <= {2'b00, thresh_q})) begin
					if (dist_q != cm) begin
						dist_next       = cm;
						event_next      = 8'd1;
						rsp_d.irq_pulse = 1'b1;
					end
				end else begin
					dist_next = cm;
				end
			end
			default: ;
		endcase

		rsp_d.servo_compare = 14'(angle_next) * SERVO_SCALE + SERVO_OFFSET;
		rsp_d.distance_cm   = dist_next;
	end

	// register map state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				buf_q[i] <= 8'd0;
			end
			idx_q    <= 3'd0;
			config_q <= 8'd0;
			angle_q  <= 8'd0;
			mode_q   <= 8'd0;
			irq_en_q <= 1'b0;
			thresh_q <= THRESHOLD_RESET;
			dist_q   <= 8'd0;
			event_q  <= 8'd0;
		end else if (fire_s1) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				if (wr_en[i]) begin
					buf_q[i] <= req_s1.rx_byte;
				end
			end
			idx_q    <= idx_next;
			config_q <= config_next;
			angle_q  <= angle_next;
			mode_q   <= mode_next;
			irq_en_q <= irq_en_next;
			thresh_q <= thresh_next;
			dist_q   <= dist_next;
			event_q  <= event_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (out_free) begin
			rsp_valid <= fire_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp <= rsp_d;
		end
	end

	// a held request only when the output side is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid)
		else $error("request stalled without a blocked response");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.irq_pulse |-> irq_en_q && (event_q == 8'd1))
		else $error("irq pulse without enabled event");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.distance_cm == dist_q) && (rsp.distance_cm <= DIST_LIMIT))
		else $error("distance out of step with register");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.servo_update |-> rsp.servo_compare ==
			14'(angle_q) * SERVO_SCALE + SERVO_OFFSET)
		else $error("servo compare does not match angle");

endmodule

>>> bench/tb_i2c_servo_sonar_register_map.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_servo_sonar_register_map
// Self-checking bench for the servo and sonar register map. Directed bus and
// echo sequences come first, then random command traffic under several idle
// and stall mixes. Every response is checked against a model kept in the bench.
// ----------------------------------------------------------------------------
module tb_i2c_servo_sonar_register_map;
	import issr_pkg::*;

	localparam int BUFFER_DEPTH = 6;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_ITEMS  = 480;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// register map state as the bench sees it
	logic [7:0] cmd_buf [BUFFER_DEPTH];
	logic [2:0] byte_idx;
	logic [7:0] cfg_reg;
	logic [7:0] servo_angle;
	logic [7:0] mode_reg;
	logic       irq_en;
	logic [5:0] irq_thr;
	logic [7:0] dist_reg;
	logic [7:0] event_reg;

	rsp_t pending_rsp [$];

	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int stall_hold         = 0;
	int requests_sent      = 0;
	int responses_checked  = 0;
	int mismatches         = 0;
	int irq_events         = 0;
	int servo_updates      = 0;

	i2c_servo_sonar_register_map #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] echo_distance(logic [15:0] rise, logic [15:0] fall);
		logic [15:0] width;
		int          signed_width;
		int          quotient;
		width        = fall - rise;
		signed_width = $signed(width);
		if (signed_width <= -ECHO_DIV)
			return DIST_LIMIT;
		// small negative widths truncate to zero
		quotient = signed_width / ECHO_DIV;
		return (quotient > DIST_LIMIT) ? DIST_LIMIT : 8'(quotient);
	endfunction

	function automatic rsp_t step_register_map(req_t r);
		rsp_t       o;
		logic [7:0] operand;
		logic [7:0] cm;
		o = '0;
		case (r.op)
			OP_ADDR: begin
				byte_idx = '0;
			end
			OP_RX: begin
				if (byte_idx < BUFFER_DEPTH)
					cmd_buf[byte_idx] = r.rx_byte;
				if (byte_idx != INDEX_MAX)
					byte_idx = byte_idx + 3'd1;
				// byte 1 may be stale, the set is applied anyway
				operand = cmd_buf[1];
				case (cmd_buf[0])
					CMD_SET_CONFIG: cfg_reg = operand;
					CMD_SET_MODE:   mode_reg = operand;
					CMD_SET_SERVO: begin
						servo_angle    = operand;
						o.servo_update = 1'b1;
					end
					CMD_SET_IRQ: begin
						irq_en  = operand[0];
						irq_thr = operand[7:2];
					end
					default: ;
				endcase
			end
			OP_TX: begin
				o.tx_valid = 1'b1;
				if (byte_idx == 3'd0) begin
					case (cmd_buf[0])
						CMD_GET_CONFIG: o.tx_byte = cfg_reg;
						CMD_GET_TYPE:   o.tx_byte = DEVICE_TYPE;
						CMD_GET_DIST:   o.tx_byte = dist_reg;
						CMD_GET_SERVO:  o.tx_byte = servo_angle;
						CMD_GET_EVENT: begin
							o.tx_byte = event_reg;
							event_reg = '0;
						end
						default: o.tx_byte = TX_FILL;
					endcase
				end else if (byte_idx == 3'd1) begin
					o.tx_byte = TX_SECOND;
				end else begin
					o.tx_byte = TX_FILL;
				end
				if (byte_idx != INDEX_MAX)
					byte_idx = byte_idx + 3'd1;
			end
			default: begin
				cm = echo_distance(r.echo_rise, r.echo_fall);
				if (irq_en && cm <= irq_thr) begin
					// inside the threshold only a change is stored
					if (dist_reg != cm) begin
						dist_reg    = cm;
						event_reg   = 8'd1;
						o.irq_pulse = 1'b1;
					end
				end else begin
					dist_reg = cm;
				end
			end
		endcase
		o.servo_compare = 14'(servo_angle * SERVO_SCALE + SERVO_OFFSET);
		o.distance_cm   = dist_reg;
		irq_events      += o.irq_pulse;
		servo_updates   += o.servo_update;
		return o;
	endfunction

	function automatic req_t make_req(op_t op, logic [7:0] data, logic [15:0] rise,
			logic [15:0] fall);
		req_t r;
		r.op        = op;
		r.rx_byte   = data;
		r.echo_rise = rise;
		r.echo_fall = fall;
		return r;
	endfunction

	function automatic logic [7:0] pick_command(bit want_get);
		if (want_get) begin
			case ($urandom_range(5))
				0: return CMD_GET_CONFIG;
				1: return CMD_GET_TYPE;
				2: return CMD_GET_EVENT;
				3: return CMD_GET_DIST;
				4: return CMD_GET_SERVO;
				default: return 8'($urandom_range(255));
			endcase
		end
		case ($urandom_range(3))
			0: return CMD_SET_CONFIG;
			1: return CMD_SET_MODE;
			2: return CMD_SET_IRQ;
			default: return CMD_SET_SERVO;
		endcase
	endfunction

	// valid stays high after acceptance; the next call either replaces or drops it
	task automatic send_request(req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(step_register_map(r));
		requests_sent++;
	endtask

	task automatic wait_for_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_rx(logic [7:0] data);
		send_request(make_req(OP_RX, data, '0, '0));
	endtask

	task automatic send_echo(logic [15:0] rise, logic [15:0] fall);
		send_request(make_req(OP_ECHO, '0, rise, fall));
	endtask

	task automatic send_simple(op_t op);
		send_request(make_req(op, '0, '0, '0));
	endtask

	task automatic test_servo_and_index();
		int i;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		send_simple(OP_ADDR);
		send_rx(CMD_SET_SERVO);
		send_rx(8'hFF);
		send_rx(8'h00);
		// fills the buffer, drops one byte and saturates the index
		for (i = 0; i < 4; i++)
			send_rx(8'h55);
		send_simple(OP_TX);
		wait_for_responses();
	endtask

	task automatic test_echo_threshold();
		send_simple(OP_ADDR);
		send_rx(CMD_SET_IRQ);
		send_rx(8'h29);  // enable, threshold ten
		send_echo(16'd0, 16'd0);
		send_echo(16'd0, 16'd580);
		send_echo(16'd1, 16'd0);
		send_echo(16'd58, 16'd0);
		send_echo(16'd0, 16'h7FFF);
		send_echo(16'h8000, 16'd0);
		send_echo(16'd0, 16'd8758);
		wait_for_responses();
	endtask

	task automatic test_event_read();
		send_simple(OP_ADDR);
		send_rx(CMD_GET_EVENT);
		send_simple(OP_ADDR);
		send_simple(OP_TX);
		send_simple(OP_TX);
		send_simple(OP_ADDR);
		send_simple(OP_TX);
		wait_for_responses();
	endtask

	task automatic test_backpressure();
		int i;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		stall_hold         = 300;
		for (i = 0; i < 40; i++)
			send_request(make_req(op_t'($urandom_range(3)), 8'($urandom_range(255)),
				16'($urandom), 16'($urandom)));
		wait_for_responses();
	endtask

	task automatic test_random_traffic(int idle_pct, int stall_pct);
		int         target;
		int         i;
		logic [15:0] rise;
		logic [15:0] fall;
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		target             = requests_sent + PHASE_ITEMS;
		while (requests_sent < target) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					send_simple(OP_ADDR);
					send_rx(pick_command(1'b0));
					send_rx(8'($urandom_range(255)));
					for (i = $urandom_range(3); i > 0; i--)
						send_rx(8'($urandom_range(255)));
				end
				4, 5: begin
					send_simple(OP_ADDR);
					send_rx(pick_command(1'b1));
					send_simple(OP_ADDR);
					for (i = $urandom_range(1, 3); i > 0; i--)
						send_simple(OP_TX);
				end
				6, 7, 8: begin
					rise = 16'($urandom);
					case ($urandom_range(3))
						0: fall = 16'($urandom);
						1: fall = rise + 16'($urandom_range(64 * 58 + 57));
						2: fall = rise - 16'($urandom_range(1, 120));
						default: fall = rise + 16'($urandom_range(140 * 58, 160 * 58));
					endcase
					send_echo(rise, fall);
				end
				default: begin
					// noise: anything in any order
					for (i = $urandom_range(1, 4); i > 0; i--)
						send_request(make_req(op_t'($urandom_range(3)),
							8'($urandom_range(255)), 16'($urandom), 16'($urandom)));
				end
			endcase
		end
		wait_for_responses();
	endtask

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	task automatic check_field(string field, int unsigned want, int unsigned got);
		if (want !== got)
			report_mismatch($sformatf("mismatch on %s at response %0d: expected %0h, got %0h",
				field, responses_checked, want, got));
	endtask

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			rsp_stall  <= 1'b1;
			stall_hold = stall_hold - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	always @(posedge clk) begin : check_responses
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("unexpected response after %0d checked: %0h",
					responses_checked, rsp));
			end else begin
				want = pending_rsp.pop_front();
				check_field("tx_byte", want.tx_byte, rsp.tx_byte);
				check_field("tx_valid", want.tx_valid, rsp.tx_valid);
				check_field("servo_update", want.servo_update, rsp.servo_update);
				check_field("servo_compare", want.servo_compare, rsp.servo_compare);
				check_field("irq_pulse", want.irq_pulse, rsp.irq_pulse);
				check_field("distance_cm", want.distance_cm, rsp.distance_cm);
				responses_checked++;
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d responses outstanding", cycles,
			pending_rsp.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		req_valid <= 1'b0;
		req       <= '0;
		rsp_stall <= 1'b0;
		arst_n    <= 1'b0;
		foreach (cmd_buf[i])
			cmd_buf[i] = '0;
		byte_idx    = '0;
		cfg_reg     = '0;
		servo_angle = '0;
		mode_reg    = '0;
		irq_en      = 1'b0;
		irq_thr     = THRESHOLD_RESET;
		dist_reg    = '0;
		event_reg   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_servo_and_index();
		test_echo_threshold();
		test_event_read();
		test_random_traffic(0, 0);
		test_random_traffic(79, 0);
		test_backpressure();
		test_random_traffic(0, 79);
		test_random_traffic(13, 13);

		receiver_stall_pct = 0;
		wait_for_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d responses checked across four idle/stall mixes",
			requests_sent, responses_checked);
		$display("%0d distance events and %0d servo writes seen, %0d mismatches",
			irq_events, servo_updates, mismatches);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/issr_pkg.sv
rtl/i2c_servo_sonar_register_map.sv
bench/tb_i2c_servo_sonar_register_map.sv
